>>> hw/rtl/tcst_pkg.sv
// ----------------------------------------------------------------------------
// tcst_pkg
// Shared codes and widths for the touch contact state tracker.
// ----------------------------------------------------------------------------
package tcst_pkg;

    localparam int IdW    = 8;
    localparam int FlagW  = 6;
    localparam int PosW   = 32;
    localparam int KindW  = 3;
    localparam int PhaseW = 2;

    typedef logic [KindW-1:0]  kind_t;
    typedef logic [PhaseW-1:0] phase_t;
    typedef logic [FlagW-1:0]  flags_t;

    // operation codes
    localparam logic OP_REPORT  = 1'b0;
    localparam logic OP_DISMISS = 1'b1;

    // contact flag bits
    localparam flags_t FL_DOWN      = 6'h01;
    localparam flags_t FL_UPDATE    = 6'h02;
    localparam flags_t FL_UP        = 6'h04;
    localparam flags_t FL_INRANGE   = 6'h08;
    localparam flags_t FL_INCONTACT = 6'h10;
    localparam flags_t FL_CANCELED  = 6'h20;

    // flag combinations that match a transition
    localparam flags_t FL_ENGAGE     = FL_DOWN | FL_INRANGE | FL_INCONTACT;
    localparam flags_t FL_HOVER_UPD  = FL_UPDATE | FL_INRANGE;
    localparam flags_t FL_HOVER_LOST = FL_UPDATE | FL_CANCELED;
    localparam flags_t FL_MOVE       = FL_UPDATE | FL_INRANGE | FL_INCONTACT;
    localparam flags_t FL_LIFT_HOVER = FL_UP | FL_INRANGE;
    localparam flags_t FL_LIFT_CANCEL = FL_UP | FL_CANCELED;

    // contact phases
    localparam phase_t PH_OUT     = 2'd0;
    localparam phase_t PH_HOVER   = 2'd1;
    localparam phase_t PH_ENGAGED = 2'd2;

    // event kinds
    localparam kind_t EV_DOWN        = 3'd0;
    localparam kind_t EV_MOTION      = 3'd1;
    localparam kind_t EV_UP          = 3'd2;
    localparam kind_t EV_CANCEL      = 3'd3;
    localparam kind_t EV_FRAME       = 3'd4;
    localparam kind_t EV_VIOLATION   = 3'd5;
    localparam kind_t EV_HOVER_BEGIN = 3'd6;
    localparam kind_t EV_HOVER_END   = 3'd7;

endpackage

>>> hw/rtl/touch_contact_state_tracker_core.sv
// ----------------------------------------------------------------------------
// touch_contact_state_tracker_core
// Per-contact touch state machine held in a synchronous table, one
// read-modify-write per item, emitting up to three events per item.
//
//  channel | dir | tdata (low bit up)                          | tuser      | tlast
//  s_      | in  | contact_idx, contact_flags, pos_x, pos_y,   | operation  | frame_end
//          |     | position_ok, pad                            |            |
//  m_      | out | event_contact, event_x, event_y             | event_kind | last
//
//  Sequence: after acceptance the lookup state reads the table, then a send step
//  puts out each event (N = events, 0..3); the next item is taken after the last.
//  Reset: per-entry valid flops clear at once; an entry never written reads as
//  out of range and not ignored, so no clearing pass is needed.
//  Stalls: m_tready low holds the output register and the event sequencer;
//  a new item is accepted while the final event still waits in the output.
// ----------------------------------------------------------------------------
module touch_contact_state_tracker_core #(
    parameter int CONTACTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // contact_idx[7:0], contact_flags[13:8], pos_x[45:14],
                                   // pos_y[77:46], position_ok[78], zero[79]
    input  logic        s_tuser,   // operation
    input  logic        s_tlast,   // frame_end
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // event_contact[7:0], event_x[39:8], event_y[71:40]
    output logic [2:0]  m_tuser,   // event_kind
    output logic        m_tlast    // last
);

    localparam int AW = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;
    localparam logic [tcst_pkg::IdW:0] ID_LIMIT = (tcst_pkg::IdW + 1)'(CONTACTS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0] state_reg, state_next;

    // contact table: {ignored, phase}
    logic [2:0]          table_mem [CONTACTS];
    logic [CONTACTS-1:0] written_reg;
    logic [2:0]          rd_data_reg;
    logic                rd_written_reg;

    // captured item
    logic                          op_reg;
    logic [tcst_pkg::IdW-1:0]      id_reg;
    tcst_pkg::flags_t              fl_reg;
    logic [tcst_pkg::PosW-1:0]     x_reg;
    logic [tcst_pkg::PosW-1:0]     y_reg;
    logic                          ok_reg;
    logic                          fend_reg;

    logic frame_pending_reg;

    // event buffer
    tcst_pkg::kind_t ev_kind_reg [3];
    logic [1:0]      ev_cnt_reg;
    logic [1:0]      ev_idx_reg;

    // output register
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic        m_tlast_reg;

    logic s_accept;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- transition logic (in ST_LOOK) ----------------
    tcst_pkg::phase_t ph, cph, nph;
    logic             ign, nign, fp_next, wr_en, in_bounds;
    tcst_pkg::kind_t  k [3];
    logic [1:0]       n;

    always_comb begin
        ph        = rd_written_reg ? rd_data_reg[1:0] : tcst_pkg::PH_OUT;
        ign       = rd_written_reg & rd_data_reg[2];
        in_bounds = ({1'b0, id_reg} < ID_LIMIT);
        cph       = ph;
        nph       = ph;
        nign      = ign;
        fp_next   = frame_pending_reg;
        wr_en     = 1'b0;
        n         = 2'd0;
        k[0]      = tcst_pkg::EV_DOWN;
        k[1]      = tcst_pkg::EV_DOWN;
        k[2]      = tcst_pkg::EV_DOWN;

        if (op_reg == tcst_pkg::OP_DISMISS) begin
            if (in_bounds && (ph == tcst_pkg::PH_HOVER || ph == tcst_pkg::PH_ENGAGED)) begin
                if (ph == tcst_pkg::PH_HOVER) begin
                    k[n] = tcst_pkg::EV_HOVER_END;
                    n    = n + 2'd1;
                end else if (!ign) begin
                    k[n]    = tcst_pkg::EV_CANCEL;
                    n       = n + 2'd1;
                    fp_next = 1'b1;
                end
                nph   = tcst_pkg::PH_OUT;
                nign  = 1'b0;
                wr_en = 1'b1;
                // dismiss flushes the pending frame
                if (fp_next) begin
                    k[n]    = tcst_pkg::EV_FRAME;
                    n       = n + 2'd1;
                    fp_next = 1'b0;
                end
            end
        end else begin
            if (in_bounds) begin
                wr_en = 1'b1;
                // hovering contact touching down: end the hover first
                if (cph == tcst_pkg::PH_HOVER && fl_reg == tcst_pkg::FL_ENGAGE) begin
                    k[n] = tcst_pkg::EV_HOVER_END;
                    n    = n + 2'd1;
                    cph  = tcst_pkg::PH_OUT;
                end
                if (cph == tcst_pkg::PH_OUT) begin
                    if (fl_reg == tcst_pkg::FL_ENGAGE) begin
                        if (ok_reg) begin
                            k[n]    = tcst_pkg::EV_DOWN;
                            n       = n + 2'd1;
                            fp_next = 1'b1;
                        end else begin
                            nign = 1'b1;
                        end
                        nph = tcst_pkg::PH_ENGAGED;
                    end else if (fl_reg == tcst_pkg::FL_HOVER_UPD) begin
                        k[n] = tcst_pkg::EV_HOVER_BEGIN;
                        n    = n + 2'd1;
                        nph  = tcst_pkg::PH_HOVER;
                    end else begin
                        k[n] = tcst_pkg::EV_VIOLATION;
                        n    = n + 2'd1;
                    end
                end else if (cph == tcst_pkg::PH_HOVER) begin
                    if (fl_reg == tcst_pkg::FL_HOVER_UPD) begin
                        nph = tcst_pkg::PH_HOVER;
                    end else if (fl_reg == tcst_pkg::FL_HOVER_LOST ||
                                 fl_reg == tcst_pkg::FL_UPDATE) begin
                        k[n] = tcst_pkg::EV_HOVER_END;
                        n    = n + 2'd1;
                        nph  = tcst_pkg::PH_OUT;
                        nign = 1'b0;
                    end else begin
                        k[n] = tcst_pkg::EV_VIOLATION;
                        n    = n + 2'd1;
                    end
                end else begin
                    if (fl_reg == tcst_pkg::FL_MOVE) begin
                        if (!ign && ok_reg) begin
                            k[n]    = tcst_pkg::EV_MOTION;
                            n       = n + 2'd1;
                            fp_next = 1'b1;
                        end
                    end else if (fl_reg == tcst_pkg::FL_LIFT_HOVER ||
                                 fl_reg == tcst_pkg::FL_UP ||
                                 fl_reg == tcst_pkg::FL_LIFT_CANCEL) begin
                        if (!ign) begin
                            k[n]    = (fl_reg == tcst_pkg::FL_LIFT_CANCEL) ?
                                      tcst_pkg::EV_CANCEL : tcst_pkg::EV_UP;
                            n       = n + 2'd1;
                            fp_next = 1'b1;
                        end
                        nign = 1'b0;
                        if (fl_reg == tcst_pkg::FL_LIFT_HOVER) begin
                            k[n] = tcst_pkg::EV_HOVER_BEGIN;
                            n    = n + 2'd1;
                            nph  = tcst_pkg::PH_HOVER;
                        end else begin
                            nph  = tcst_pkg::PH_OUT;
                        end
                    end else begin
                        k[n] = tcst_pkg::EV_VIOLATION;
                        n    = n + 2'd1;
                    end
                end
            end
            if (fend_reg && fp_next) begin
                k[n]    = tcst_pkg::EV_FRAME;
                n       = n + 2'd1;
                fp_next = 1'b0;
            end
        end
    end

    // ---------------- contact table ----------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK && wr_en) begin
            table_mem[id_reg[AW-1:0]] <= {nign, nph};
        end
        if (s_accept) begin
            rd_data_reg <= table_mem[s_tdata[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (state_reg == ST_LOOK && wr_en) begin
                written_reg[id_reg[AW-1:0]] <= 1'b1;
            end
            if (s_accept) begin
                rd_written_reg <= written_reg[s_tdata[AW-1:0]];
            end
        end
    end

    // ---------------- item capture ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= s_tuser;
            id_reg   <= s_tdata[7:0];
            fl_reg   <= s_tdata[13:8];
            x_reg    <= s_tdata[45:14];
            y_reg    <= s_tdata[77:46];
            ok_reg   <= s_tdata[78];
            fend_reg <= s_tlast;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                state_next = (n == 2'd0) ? ST_IDLE : ST_SEND;
            end
            ST_SEND: begin
                if (out_free && ev_idx_reg == ev_cnt_reg - 2'd1) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            frame_pending_reg <= 1'b0;
            ev_cnt_reg        <= 2'd0;
            ev_idx_reg        <= 2'd0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_LOOK) begin
                frame_pending_reg <= fp_next;
                ev_cnt_reg        <= n;
                ev_idx_reg        <= 2'd0;
            end
            if (state_reg == ST_SEND && out_free) begin
                m_tvalid_reg <= 1'b1;
                ev_idx_reg   <= ev_idx_reg + 2'd1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // event buffer and output payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK) begin
            ev_kind_reg[0] <= k[0];
            ev_kind_reg[1] <= k[1];
            ev_kind_reg[2] <= k[2];
        end
        if (state_reg == ST_SEND && out_free) begin
            m_tuser_reg       <= ev_kind_reg[ev_idx_reg];
            m_tlast_reg       <= (ev_idx_reg == ev_cnt_reg - 2'd1);
            m_tdata_reg[7:0]  <= (ev_kind_reg[ev_idx_reg] == tcst_pkg::EV_FRAME) ?
                                 8'd0 : id_reg;
            if (ev_kind_reg[ev_idx_reg] == tcst_pkg::EV_DOWN ||
                ev_kind_reg[ev_idx_reg] == tcst_pkg::EV_MOTION) begin
                m_tdata_reg[39:8]  <= x_reg;
                m_tdata_reg[71:40] <= y_reg;
            end else begin
                m_tdata_reg[39:8]  <= '0;
                m_tdata_reg[71:40] <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    // table lookup only follows an accepted item
    a_look_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |-> $past(s_accept))
        else $error("lookup without accepted item");

    // sequencer never runs past the buffered events
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> (ev_idx_reg < ev_cnt_reg))
        else $error("event index past count");

    // a report with frame end leaves no frame pending
    a_frame_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK && op_reg == tcst_pkg::OP_REPORT && fend_reg)
        |=> !frame_pending_reg)
        else $error("frame still pending after frame end");

    // table never takes an unused phase code
    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK && wr_en) |-> (nph != 2'd3))
        else $error("illegal phase written");
`endif

endmodule
